### hw/rtl/pelco_d_frame_transceiver_top_defines.svh
// Assertion macros shared by the frame transceiver RTL.
`ifndef PELCO_D_FRAME_TRANSCEIVER_TOP_DEFINES_SVH
`define PELCO_D_FRAME_TRANSCEIVER_TOP_DEFINES_SVH

`ifndef SYNTH
// Check that prop holds at every clock edge outside reset.
`define PDFT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Check that cond never holds outside reset.
`define PDFT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define PDFT_ASSERT(label, prop, msg)
`define PDFT_NEVER(label, cond, msg)
`endif

`endif

### hw/rtl/pdft_pkg.sv
// Types, codes and helper functions of the frame transceiver.
`timescale 1ns / 1ps
package pdft_pkg;

   localparam int FRAME_BYTES = 7;
   localparam int TIMER_BITS = 16;
   localparam int IDX_BITS = $clog2(FRAME_BYTES);
   localparam int FILL_BITS = $clog2(FRAME_BYTES + 1);

   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [7:0] DEF_ADDRESS = 8'h01;
   localparam logic [7:0] DEF_ECHO_MS = 8'd10;

   // request opcodes
   localparam logic [1:0] OP_RX = 2'd0;
   localparam logic [1:0] OP_SEND = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   // configuration register indexes
   localparam logic CSR_ADDRESS = 1'b0;
   localparam logic CSR_ECHO_MS = 1'b1;

   // result kinds
   localparam logic KIND_TX = 1'b0;
   localparam logic KIND_REPLY = 1'b1;

   // reply classes
   localparam logic [2:0] CLS_SWITCH = 3'd0;
   localparam logic [2:0] CLS_BRIGHT = 3'd1;
   localparam logic [2:0] CLS_POSITION = 3'd2;
   localparam logic [2:0] CLS_ANGLE = 3'd3;
   localparam logic [2:0] CLS_FAN = 3'd4;
   localparam logic [2:0] CLS_VERSION = 3'd5;
   localparam logic [2:0] CLS_UNPARSED = 3'd6;

   typedef logic [FRAME_BYTES-1:0][7:0] frame_type;

   typedef struct packed {
      logic        laser_on;
      logic        fan_on;
      logic [7:0]  brightness;
      logic [15:0] position;
      logic [15:0] angle;
   } status_type;

   typedef struct packed {
      logic       good;
      frame_type  bytes;
   } rx_frame_type;

   typedef struct packed {
      logic       kind;
      frame_type  bytes;
      logic [2:0] cls;
      status_type status;
   } job_type;

   typedef struct packed {
      logic        valid;
      logic        kind;
      logic [7:0]  tx_byte;
      logic        last;
      logic [2:0]  cls;
      logic [7:0]  cmd_one;
      logic [7:0]  cmd_two;
      logic [15:0] payload;
      status_type  status;
   } rsp_type;

   function automatic logic [7:0] frame_sum(input frame_type f);
      logic [7:0] s;
      s = f[1] + f[2] + f[3] + f[4] + f[5];
      return s;
   endfunction

   function automatic logic [2:0] classify(input logic [7:0] c1, input logic [7:0] c2);
      logic [2:0] c;
      if (c1 == 8'h02 && c2 == 8'h01) c = CLS_SWITCH;
      else if (c1 == 8'h02 && c2 == 8'h03) c = CLS_BRIGHT;
      else if (c1 == 8'h02 && c2 == 8'h05) c = CLS_POSITION;
      else if (c1 == 8'h09 && c2 == 8'h01) c = CLS_ANGLE;
      else if (c1 == 8'h02 && c2 == 8'h0F) c = CLS_FAN;
      else if (c1 == 8'h20 || c1 == 8'h21 || c1 == 8'h22) c = CLS_VERSION;
      else c = CLS_UNPARSED;
      return c;
   endfunction

endpackage

### hw/rtl/pelco_d_frame_transceiver_top.sv
// Frame transceiver top level: sending, echo filter, status and timer.
//
// Request channel (req_*): opcode 0 delivers a received serial byte, opcode 1
// sends a frame built from device_address and the four command/data bytes,
// opcode 2 is a one-millisecond tick, opcode 3 is ignored.
// Response channel (rsp_*): a send yields seven transmit results (FF, address,
// cmd1, cmd2, data1, data2, checksum), the last flagged by rsp_last_of_run.
// A received byte that completes a good frame, other than a local echo,
// yields one reply result with its class. Every result carries the status
// registers as updated by its own request.
// The first result of a request is registered in the queue and offered once
// the results ahead of it have been taken.
// Throughput: one request per cycle; a two-entry result queue takes the next
// request while a result waits, so req_stall rises only when both entries
// hold work, and a send occupies the output for its seven transmit results.
// Stalling the response channel holds the current result and, once the queue
// is full, stalls the request channel.
// Reset: empties the queue and window, clears the status, sets the ms
// counter to all ones, device_address to 1 and echo_window_ms to 10.
// csr_*: write-only registers, index 0 device_address, 1 echo_window_ms.
`timescale 1ns / 1ps
module pelco_d_frame_transceiver_top
   import pdft_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_rx_byte,
   input  logic [7:0]  req_command_one,
   input  logic [7:0]  req_command_two,
   input  logic [7:0]  req_data_one,
   input  logic [7:0]  req_data_two,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last_of_run,
   output logic [2:0]  rsp_reply_class,
   output logic [7:0]  rsp_reply_cmd_one,
   output logic [7:0]  rsp_reply_cmd_two,
   output logic [15:0] rsp_reply_payload,
   output logic        rsp_laser_on,
   output logic        rsp_fan_on,
   output logic [7:0]  rsp_brightness_level,
   output logic [15:0] rsp_travel_position,
   output logic [15:0] rsp_angle_centideg,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   logic [7:0]            address_ff, echo_ms_ff;
   frame_type             sent_ff, sent_in;
   logic                  sent_valid_ff, sent_valid_in;
   logic [TIMER_BITS-1:0] ms_ff, ms_in;
   status_type            status_ff, status_in;

   logic         accept, is_rx, is_send, is_tick;
   rx_frame_type rx_frame;
   frame_type    tx_frame;
   logic         echo, reply;
   logic [2:0]   cls;
   logic         push;
   job_type      job;
   logic         q_full;
   rsp_type      rsp;

   assign accept = req_valid && !req_stall;
   assign is_rx = accept && req_opcode == OP_RX;
   assign is_send = accept && req_opcode == OP_SEND;
   assign is_tick = accept && req_opcode == OP_TICK;
   assign req_stall = q_full;

   pdft_rx u_rx (
      .clock   (clock),
      .reset   (reset),
      .take    (is_rx),
      .rx_byte (req_rx_byte),
      .frame   (rx_frame)
   );

   always_comb begin
      tx_frame[0] = SYNC_BYTE;
      tx_frame[1] = address_ff;
      tx_frame[2] = req_command_one;
      tx_frame[3] = req_command_two;
      tx_frame[4] = req_data_one;
      tx_frame[5] = req_data_two;
      tx_frame[6] = 8'h00;
      tx_frame[6] = frame_sum(tx_frame);
   end

   assign echo = sent_valid_ff && (rx_frame.bytes == sent_ff) &&
                 (ms_ff <= TIMER_BITS'(echo_ms_ff));
   assign reply = rx_frame.good && !echo;
   assign cls = classify(rx_frame.bytes[2], rx_frame.bytes[3]);

   always_comb begin
      status_in = status_ff;
      if (reply) begin
         case (cls)
            CLS_SWITCH:   status_in.laser_on = (rx_frame.bytes[4] != 8'h00);
            CLS_BRIGHT:   status_in.brightness = rx_frame.bytes[4];
            CLS_POSITION: status_in.position = {rx_frame.bytes[4], rx_frame.bytes[5]};
            CLS_ANGLE:    status_in.angle = {rx_frame.bytes[4], rx_frame.bytes[5]};
            CLS_FAN:      status_in.fan_on = (rx_frame.bytes[4] != 8'h00);
            default:      status_in = status_ff;
         endcase
      end
   end

   always_comb begin
      sent_in = sent_ff;
      sent_valid_in = sent_valid_ff;
      ms_in = ms_ff;
      if (is_send) begin
         sent_in = tx_frame;
         sent_valid_in = 1'b1;
         ms_in = '0;
      end else if (is_tick && ms_ff != '1) begin
         ms_in = ms_ff + TIMER_BITS'(1);
      end
   end

   assign push = is_send || reply;
   always_comb begin
      job.kind = is_send ? KIND_TX : KIND_REPLY;
      job.bytes = is_send ? tx_frame : rx_frame.bytes;
      job.cls = cls;
      job.status = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff <= DEF_ADDRESS;
         echo_ms_ff <= DEF_ECHO_MS;
         sent_ff <= '0;
         sent_valid_ff <= 1'b0;
         ms_ff <= '1;
         status_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ADDRESS: address_ff <= csr_wdata;
               CSR_ECHO_MS: echo_ms_ff <= csr_wdata;
               default:     address_ff <= address_ff;
            endcase
         end
         sent_ff <= sent_in;
         sent_valid_ff <= sent_valid_in;
         ms_ff <= ms_in;
         status_ff <= status_in;
      end
   end

   pdft_jobq u_jobq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (job),
      .rsp_stall (rsp_stall),
      .full      (q_full),
      .rsp       (rsp)
   );

   assign rsp_valid = rsp.valid;
   assign rsp_result_kind = rsp.kind;
   assign rsp_tx_byte = rsp.tx_byte;
   assign rsp_last_of_run = rsp.last;
   assign rsp_reply_class = rsp.cls;
   assign rsp_reply_cmd_one = rsp.cmd_one;
   assign rsp_reply_cmd_two = rsp.cmd_two;
   assign rsp_reply_payload = rsp.payload;
   assign rsp_laser_on = rsp.status.laser_on;
   assign rsp_fan_on = rsp.status.fan_on;
   assign rsp_brightness_level = rsp.status.brightness;
   assign rsp_travel_position = rsp.status.position;
   assign rsp_angle_centideg = rsp.status.angle;

endmodule

### hw/rtl/pdft_rx.sv
// Receive window: sync hunt, checksum check and resync after a bad frame.
`timescale 1ns / 1ps
module pdft_rx
   import pdft_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         take,
   input  logic [7:0]   rx_byte,
   output rx_frame_type frame
);

   frame_type             window_ff, window_in;
   logic [FILL_BITS-1:0]  fill_ff, fill_in;
   frame_type             w;
   logic [IDX_BITS-1:0]   k;
   logic                  found;

   always_comb begin
      window_in = window_ff;
      fill_in = fill_ff;
      w = window_ff;
      k = IDX_BITS'(1);
      found = 1'b0;
      frame.good = 1'b0;
      w[fill_ff[IDX_BITS-1:0]] = rx_byte;
      frame.bytes = w;
      if (take && !(fill_ff == '0 && rx_byte != SYNC_BYTE)) begin
         if (fill_ff != FILL_BITS'(FRAME_BYTES - 1)) begin
            window_in = w;
            fill_in = fill_ff + FILL_BITS'(1);
         end else if (w[FRAME_BYTES-1] == frame_sum(w)) begin
            frame.good = 1'b1;
            fill_in = '0;
         end else begin
            // drop the lead byte, then resync on the next FF in the window
            for (int i = FRAME_BYTES - 1; i >= 1; i--) begin
               if (w[i] == SYNC_BYTE) begin
                  k = IDX_BITS'(i);
                  found = 1'b1;
               end
            end
            window_in = w >> (8 * k);
            fill_in = found ? FILL_BITS'(FRAME_BYTES) - FILL_BITS'(k) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         fill_ff <= '0;
      end else begin
         window_ff <= window_in;
         fill_ff <= fill_in;
      end
   end

endmodule

### hw/rtl/pdft_jobq.sv
// Two-slot result queue; plays a transmit run out one byte per cycle while rsp_stall is low.
`timescale 1ns / 1ps
`include "pelco_d_frame_transceiver_top_defines.svh"
module pdft_jobq
   import pdft_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    rsp_stall,
   output logic    full,
   output rsp_type rsp
);

   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(FRAME_BYTES - 1);

   job_type              a_ff, a_in, b_ff, b_in;
   logic                 a_valid_ff, a_valid_in, b_valid_ff, b_valid_in;
   logic [IDX_BITS-1:0]  idx_ff, idx_in;
   logic                 send, is_tx, pop;

   assign is_tx = (a_ff.kind == KIND_TX);
   assign send = a_valid_ff && !rsp_stall;
   assign pop = send && (!is_tx || idx_ff == LAST_IDX);
   assign full = b_valid_ff;

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      a_valid_in = a_valid_ff;
      b_valid_in = b_valid_ff;
      idx_in = idx_ff;
      if (!a_valid_ff || pop) begin
         idx_in = '0;
         if (b_valid_ff) begin
            a_in = b_ff;
            a_valid_in = 1'b1;
            b_valid_in = 1'b0;
         end else begin
            a_in = push_job;
            a_valid_in = push;
         end
      end else begin
         if (send) idx_in = idx_ff + IDX_BITS'(1);
         // hold the new request behind the one still draining
         if (push) begin
            b_in = push_job;
            b_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         idx_ff <= idx_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
   end

   always_comb begin
      rsp.valid = a_valid_ff;
      rsp.kind = a_ff.kind;
      rsp.status = a_ff.status;
      if (is_tx) begin
         rsp.tx_byte = a_ff.bytes[idx_ff];
         rsp.last = (idx_ff == LAST_IDX);
         rsp.cls = '0;
         rsp.cmd_one = '0;
         rsp.cmd_two = '0;
         rsp.payload = '0;
      end else begin
         rsp.tx_byte = '0;
         rsp.last = 1'b0;
         rsp.cls = a_ff.cls;
         rsp.cmd_one = a_ff.bytes[2];
         rsp.cmd_two = a_ff.bytes[3];
         rsp.payload = {a_ff.bytes[4], a_ff.bytes[5]};
      end
   end

   `PDFT_ASSERT(a_b_order, b_valid_ff |-> a_valid_ff, "second slot filled ahead of first")
   `PDFT_NEVER(reply_idx_zero, a_valid_ff && !is_tx && idx_ff != '0, "reply with run index")
   `PDFT_ASSERT(b_holds, (b_valid_ff && !pop) |=> b_valid_ff, "queued request lost")
   `PDFT_NEVER(push_when_full, push && b_valid_ff, "request taken with queue full")

endmodule
